>>> src/pgts_pkg.sv
// Package with shared types, constants and arithmetic helpers of the probe grid sampler.
`timescale 1ns / 1ps
package pgts_pkg;

	// Store geometry
	localparam int GridCells  = 4096;
	localparam int AddrW      = 12;
	localparam int WordW      = 64;
	localparam int AxisMax    = 64;
	localparam int Copies     = 4;

	// Queue between the front and back parts
	localparam int QDepth     = 8;
	localparam int QPtrW      = 3;
	localparam int QCntW      = 4;
	localparam int FrontDepth = 4;

	// Item kinds
	localparam logic [1:0] KindAmbient  = 2'd0;
	localparam logic [1:0] KindDominant = 2'd1;
	localparam logic [1:0] KindQuery    = 2'd2;
	localparam logic [1:0] KindUnused   = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] RegOriginX = 3'd0;
	localparam logic [2:0] RegOriginY = 3'd1;
	localparam logic [2:0] RegOriginZ = 3'd2;
	localparam logic [2:0] RegInvCell = 3'd3;
	localparam logic [2:0] RegSizeX   = 3'd4;
	localparam logic [2:0] RegSizeY   = 3'd5;
	localparam logic [2:0] RegSizeZ   = 3'd6;

	typedef struct packed {
		logic [1:0]         kind;
		logic [11:0]        cell_address;
		logic signed [15:0] value_0;
		logic signed [15:0] value_1;
		logic signed [15:0] value_2;
		logic signed [15:0] value_3;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] ambient_0;
		logic signed [15:0] ambient_1;
		logic signed [15:0] ambient_2;
		logic signed [15:0] ambient_3;
		logic signed [15:0] dominant_0;
		logic signed [15:0] dominant_1;
		logic signed [15:0] dominant_2;
		logic signed [15:0] dominant_3;
		logic               covered;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic [31:0]        inv_cell_size;
		logic [6:0]         size_x;
		logic [6:0]         size_y;
		logic [6:0]         size_z;
	} cfg_t;

	typedef struct packed {
		logic [1:0]             kind;
		logic [AddrW-1:0]       cell_address;
		logic [WordW-1:0]       wdata;
		logic [7:0][AddrW-1:0]  corner;
		logic [2:0][15:0]       frac;
		logic                   covered;
	} q_entry_t;

	typedef struct packed {
		logic empty;
		logic near_full;
	} q_stat_t;

	// Axis size limited to the largest supported grid.
	function automatic logic [6:0] clamp_size(input logic [6:0] size);
		return (size > 7'(AxisMax)) ? 7'(AxisMax) : size;
	endfunction

	// Product (b - a) * t of one lerp step.
	function automatic logic signed [33:0] lerp_mul(input logic signed [15:0] a,
			input logic signed [15:0] b, input logic [15:0] t);
		logic signed [16:0] diff;
		logic signed [16:0] ts;
		diff = 17'(b) - 17'(a);
		ts = signed'({1'b0, t});
		return diff * ts;
	endfunction

	// a plus the product shifted down with rounding toward minus infinity.
	function automatic logic signed [15:0] lerp_add(input logic signed [15:0] a,
			input logic signed [33:0] p);
		logic signed [17:0] s;
		s = 18'(a) + 18'(p >>> 16);
		return s[15:0];
	endfunction

endpackage

>>> src/probe_grid_trilinear_sampler.sv
// Top level of the probe grid trilinear sampler.
//
// Items enter on start/item and are taken at any edge where start is high and
// busy is low. Kinds 0 and 1 write one cell of the ambient or dominant grid and
// give no result; kind 2 queries a world position and gives one result; kind 3
// is dropped. One item can be taken every cycle while busy is low.
// A query result loads into result and is marked by done for exactly one
// cycle. On its way the item passes four front stages that map the position
// to corners, the queue slot, the memory read and four blend stages. The
// receiver cannot stall; the back part drains the queue every cycle, so busy
// stays low in normal use. Writes and queries keep their order through the
// queue, so a query sees every earlier write.
// Configuration is written through cfg_we/cfg_index/cfg_data while the block
// is idle. Reset clears the registers to origin 0, reciprocal 1.0 and sizes 0;
// the cell stores hold no defined contents until written.
`timescale 1ns / 1ps
module probe_grid_trilinear_sampler (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  pgts_pkg::in_item_t  item,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output logic                done,
	output pgts_pkg::out_item_t result
);

	pgts_pkg::cfg_t cfg_q;
	pgts_pkg::q_stat_t q_stat;
	pgts_pkg::q_entry_t f_entry, b_entry;
	logic f_push;
	logic b_vld;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x      <= '0;
			cfg_q.origin_y      <= '0;
			cfg_q.origin_z      <= '0;
			cfg_q.inv_cell_size <= 32'd65536;
			cfg_q.size_x        <= '0;
			cfg_q.size_y        <= '0;
			cfg_q.size_z        <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pgts_pkg::RegOriginX: cfg_q.origin_x      <= cfg_data;
				pgts_pkg::RegOriginY: cfg_q.origin_y      <= cfg_data;
				pgts_pkg::RegOriginZ: cfg_q.origin_z      <= cfg_data;
				pgts_pkg::RegInvCell: cfg_q.inv_cell_size <= cfg_data;
				pgts_pkg::RegSizeX:   cfg_q.size_x        <= cfg_data[6:0];
				pgts_pkg::RegSizeY:   cfg_q.size_y        <= cfg_data[6:0];
				pgts_pkg::RegSizeZ:   cfg_q.size_z        <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	pgts_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.cfg    (cfg_q),
		.q_stat (q_stat),
		.push   (f_push),
		.entry  (f_entry)
	);

	pgts_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.din    (f_entry),
		.pop    (1'b1),
		.dout   (b_entry),
		.stat   (q_stat)
	);

	// The back part never stalls, so the head is taken whenever present.
	assign b_vld = !q_stat.empty;

	pgts_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (b_vld),
		.entry  (b_entry),
		.done   (done),
		.result (result)
	);

endmodule

>>> src/pgts_front.sv
// Front part: accepts items, maps positions to cell corners and fractions.
`timescale 1ns / 1ps
module pgts_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  pgts_pkg::in_item_t item,
	input  pgts_pkg::cfg_t     cfg,
	input  pgts_pkg::q_stat_t  q_stat,
	output logic               push,
	output pgts_pkg::q_entry_t entry
);

	logic accept;
	logic signed [31:0] pos [3];
	logic signed [31:0] org [3];
	logic [6:0] n [3];
	logic [5:0] nm1 [3];

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic [1:0] kind_s1, kind_s2, kind_s3, kind_s4;
	logic [11:0] addr_s1, addr_s2, addr_s3, addr_s4;
	logic [63:0] wdata_s1, wdata_s2, wdata_s3, wdata_s4;
	logic ok_s1, ok_s2, ok_s3, ok_s4;
	logic signed [32:0] d_s1 [3];
	logic [47:0] ph_s2 [3];
	logic [31:0] pl_s2 [3];
	logic [21:0] f_s3 [3];
	logic [11:0] zy_s4 [4];
	logic [5:0] x0_s4, x1_s4;
	logic [15:0] t_s4 [3];

	logic [5:0] c0 [3];
	logic [5:0] c1 [3];
	logic [11:0] zy [4];
	logic [11:0] idx [8];

	// Item accept; unused kinds are dropped here.
	assign busy   = q_stat.near_full;
	assign accept = start && !busy && (item.kind != pgts_pkg::KindUnused);

	assign pos[0] = item.pos_x;
	assign pos[1] = item.pos_y;
	assign pos[2] = item.pos_z;
	assign org[0] = cfg.origin_x;
	assign org[1] = cfg.origin_y;
	assign org[2] = cfg.origin_z;
	assign n[0] = pgts_pkg::clamp_size(cfg.size_x);
	assign n[1] = pgts_pkg::clamp_size(cfg.size_y);
	assign n[2] = pgts_pkg::clamp_size(cfg.size_z);
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			nm1[a] = 6'(n[a] - 7'd1);
		end
	end

	// Valid bits of the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Stage 1: offset from the grid origin.
	always_ff @(posedge clk) begin
		kind_s1  <= item.kind;
		addr_s1  <= item.cell_address;
		wdata_s1 <= {item.value_3, item.value_2, item.value_1, item.value_0};
		ok_s1    <= (cfg.size_x != 7'd0) && (cfg.size_y != 7'd0) && (cfg.size_z != 7'd0);
		for (int a = 0; a < 3; a++) begin
			d_s1[a] <= 33'(pos[a]) - 33'(org[a]);
		end
	end

	// Stage 2: scale by the reciprocal cell size, split in two partial products.
	always_ff @(posedge clk) begin
		logic [31:0] ud;
		logic [47:0] lo;
		kind_s2  <= kind_s1;
		addr_s2  <= addr_s1;
		wdata_s2 <= wdata_s1;
		ok_s2    <= ok_s1;
		for (int a = 0; a < 3; a++) begin
			ud = (d_s1[a] > 33'sd0) ? d_s1[a][31:0] : 32'd0;
			lo = {16'd0, ud} * {32'd0, cfg.inv_cell_size[15:0]};
			ph_s2[a] <= {16'd0, ud} * {32'd0, cfg.inv_cell_size[31:16]};
			pl_s2[a] <= lo[47:16];
		end
	end

	// Stage 3: sum and clamp to the far cell.
	always_ff @(posedge clk) begin
		logic [48:0] sum;
		logic [48:0] hi;
		kind_s3  <= kind_s2;
		addr_s3  <= addr_s2;
		wdata_s3 <= wdata_s2;
		ok_s3    <= ok_s2;
		for (int a = 0; a < 3; a++) begin
			sum = 49'(ph_s2[a]) + 49'(pl_s2[a]);
			hi  = 49'({nm1[a], 16'd0});
			f_s3[a] <= (sum > hi) ? hi[21:0] : sum[21:0];
		end
	end

	// Corner cells and the z*ny+y row bases.
	always_comb begin
		logic [6:0] nxt;
		logic [5:0] zs, ys;
		logic [12:0] zp;
		for (int a = 0; a < 3; a++) begin
			c0[a] = f_s3[a][21:16];
			nxt   = {1'b0, c0[a]} + 7'd1;
			c1[a] = (nxt < n[a]) ? nxt[5:0] : nm1[a];
		end
		for (int j = 0; j < 4; j++) begin
			zs = j[1] ? c1[2] : c0[2];
			ys = j[0] ? c1[1] : c0[1];
			zp = 13'(zs) * 13'(n[1]);
			zy[j] = zp[11:0] + 12'(ys);
		end
	end

	// Stage 4: row bases, x corners and fractions.
	always_ff @(posedge clk) begin
		kind_s4  <= kind_s3;
		addr_s4  <= addr_s3;
		wdata_s4 <= wdata_s3;
		ok_s4    <= ok_s3;
		x0_s4    <= c0[0];
		x1_s4    <= c1[0];
		for (int j = 0; j < 4; j++) begin
			zy_s4[j] <= zy[j];
		end
		for (int a = 0; a < 3; a++) begin
			t_s4[a] <= f_s3[a][15:0];
		end
	end

	// Linear corner indexes, wrapped to the store size.
	always_comb begin
		logic [18:0] p;
		for (int c = 0; c < 8; c++) begin
			p = 19'(zy_s4[c / 2]) * 19'(n[0]);
			idx[c] = p[11:0] + 12'(c[0] ? x1_s4 : x0_s4);
		end
	end

	// Queue entry.
	always_comb begin
		entry.kind         = kind_s4;
		entry.cell_address = addr_s4;
		entry.wdata        = wdata_s4;
		entry.covered      = ok_s4;
		for (int c = 0; c < 8; c++) begin
			entry.corner[c] = idx[c];
		end
		for (int a = 0; a < 3; a++) begin
			entry.frac[a] = t_s4[a];
		end
	end
	assign push = vld_s4;

endmodule

>>> src/pgts_queue.sv
// Queue of classified items between the front and back parts.
`timescale 1ns / 1ps
module pgts_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pgts_pkg::q_entry_t din,
	input  logic               pop,
	output pgts_pkg::q_entry_t dout,
	output pgts_pkg::q_stat_t  stat
);

	pgts_pkg::q_entry_t slot_q [pgts_pkg::QDepth];
	logic [pgts_pkg::QPtrW-1:0] wr_q, rd_q;
	logic [pgts_pkg::QCntW-1:0] cnt_q;
	logic do_pop;

	assign do_pop = pop && (cnt_q != '0);
	assign dout = slot_q[rd_q];
	assign stat.empty = (cnt_q == '0);
	// Room is kept for every item still in the front stages.
	assign stat.near_full = (cnt_q >= pgts_pkg::QCntW'(pgts_pkg::QDepth - pgts_pkg::FrontDepth));

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + pgts_pkg::QCntW'(push) - pgts_pkg::QCntW'(do_pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= din;
		end
	end

endmodule

>>> src/pgts_ram.sv
// Cell store copy with one write port and two registered read ports.
`timescale 1ns / 1ps
module pgts_ram (
	input  logic                         clk,
	input  logic                         we,
	input  logic [pgts_pkg::AddrW-1:0]   waddr,
	input  logic [pgts_pkg::WordW-1:0]   wdata,
	input  logic [pgts_pkg::AddrW-1:0]   raddr_a,
	input  logic [pgts_pkg::AddrW-1:0]   raddr_b,
	output logic [pgts_pkg::WordW-1:0]   rdata_a,
	output logic [pgts_pkg::WordW-1:0]   rdata_b
);

	logic [pgts_pkg::WordW-1:0] mem [pgts_pkg::GridCells];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read ports.
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> src/pgts_back.sv
// Back part: cell writes, corner fetch and trilinear blend of both grids.
`timescale 1ns / 1ps
module pgts_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld,
	input  pgts_pkg::q_entry_t  entry,
	output logic                done,
	output pgts_pkg::out_item_t result
);

	logic we_amb, we_dom, is_query;
	logic [63:0] rd [2][8];

	logic qv_s1, qv_s2, qv_s3, qv_s4;
	logic cov_s1, cov_s2, cov_s3, cov_s4;
	logic [15:0] t_s1 [3];
	logic [15:0] t_s2 [3];
	logic [15:0] t_s3 [3];
	logic signed [33:0] px_s2 [2][4][4];
	logic signed [15:0] ax_s2 [2][4][4];
	logic signed [33:0] py_s3 [2][4][2];
	logic signed [15:0] ay_s3 [2][4][2];
	logic signed [33:0] pz_s4 [2][4];
	logic signed [15:0] az_s4 [2][4];
	logic done_q;
	pgts_pkg::out_item_t result_q;

	assign we_amb   = vld && (entry.kind == pgts_pkg::KindAmbient);
	assign we_dom   = vld && (entry.kind == pgts_pkg::KindDominant);
	assign is_query = vld && (entry.kind == pgts_pkg::KindQuery);

	// Each grid lives in four identical copies so all eight corners read at once.
	for (genvar g = 0; g < 2; g++) begin : g_grid
		for (genvar i = 0; i < pgts_pkg::Copies; i++) begin : g_copy
			pgts_ram u_ram (
				.clk     (clk),
				.we      ((g == 0) ? we_amb : we_dom),
				.waddr   (entry.cell_address),
				.wdata   (entry.wdata),
				.raddr_a (entry.corner[2*i]),
				.raddr_b (entry.corner[2*i+1]),
				.rdata_a (rd[g][2*i]),
				.rdata_b (rd[g][2*i+1])
			);
		end
	end

	// Valid bits of the blend stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s1  <= 1'b0;
			qv_s2  <= 1'b0;
			qv_s3  <= 1'b0;
			qv_s4  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			qv_s1  <= is_query;
			qv_s2  <= qv_s1;
			qv_s3  <= qv_s2;
			qv_s4  <= qv_s3;
			done_q <= qv_s4;
		end
	end

	// Stage 1: fractions and coverage ride along with the memory read.
	always_ff @(posedge clk) begin
		cov_s1 <= entry.covered;
		for (int a = 0; a < 3; a++) begin
			t_s1[a] <= entry.frac[a];
		end
	end

	// Stage 2: products along x.
	always_ff @(posedge clk) begin
		logic signed [15:0] a0, b0;
		cov_s2 <= cov_s1;
		t_s2   <= t_s1;
		for (int g = 0; g < 2; g++) begin
			for (int k = 0; k < 4; k++) begin
				for (int j = 0; j < 4; j++) begin
					a0 = rd[g][2*j][16*k +: 16];
					b0 = rd[g][2*j+1][16*k +: 16];
					px_s2[g][k][j] <= pgts_pkg::lerp_mul(a0, b0, t_s1[0]);
					ax_s2[g][k][j] <= a0;
				end
			end
		end
	end

	// Stage 3: finish x, products along y.
	always_ff @(posedge clk) begin
		logic signed [15:0] va, vb;
		cov_s3 <= cov_s2;
		t_s3   <= t_s2;
		for (int g = 0; g < 2; g++) begin
			for (int k = 0; k < 4; k++) begin
				for (int m = 0; m < 2; m++) begin
					va = pgts_pkg::lerp_add(ax_s2[g][k][2*m], px_s2[g][k][2*m]);
					vb = pgts_pkg::lerp_add(ax_s2[g][k][2*m+1], px_s2[g][k][2*m+1]);
					py_s3[g][k][m] <= pgts_pkg::lerp_mul(va, vb, t_s2[1]);
					ay_s3[g][k][m] <= va;
				end
			end
		end
	end

	// Stage 4: finish y, products along z.
	always_ff @(posedge clk) begin
		logic signed [15:0] va, vb;
		cov_s4 <= cov_s3;
		for (int g = 0; g < 2; g++) begin
			for (int k = 0; k < 4; k++) begin
				va = pgts_pkg::lerp_add(ay_s3[g][k][0], py_s3[g][k][0]);
				vb = pgts_pkg::lerp_add(ay_s3[g][k][1], py_s3[g][k][1]);
				pz_s4[g][k] <= pgts_pkg::lerp_mul(va, vb, t_s3[2]);
				az_s4[g][k] <= va;
			end
		end
	end

	// Output register; an invalid grid gives all zeros.
	always_ff @(posedge clk) begin
		logic signed [15:0] r [2][4];
		for (int g = 0; g < 2; g++) begin
			for (int k = 0; k < 4; k++) begin
				r[g][k] = cov_s4 ? pgts_pkg::lerp_add(az_s4[g][k], pz_s4[g][k]) : 16'sd0;
			end
		end
		result_q.ambient_0  <= r[0][0];
		result_q.ambient_1  <= r[0][1];
		result_q.ambient_2  <= r[0][2];
		result_q.ambient_3  <= r[0][3];
		result_q.dominant_0 <= r[1][0];
		result_q.dominant_1 <= r[1][1];
		result_q.dominant_2 <= r[1][2];
		result_q.dominant_3 <= r[1][3];
		result_q.covered    <= cov_s4;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
